@@ sv/lru_pkg.sv @@
// Shared types and constants for the LRU size latch table.
// No dependencies; used by every module of the block.
package lru_pkg;

    localparam int SLOTS = 16;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int TOP_SHIFT = 4;

    localparam logic [1:0] CMD_LATCH    = 2'd0;
    localparam logic [1:0] CMD_LOOKUP   = 2'd1;
    localparam logic [1:0] CMD_FORGET   = 2'd2;
    // Unused command code; the block ignores it.
    localparam logic [1:0] CMD_RESERVED = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] key;
        logic [15:0] size_value;
        logic [31:0] block_capacity;
    } t_in;

    typedef struct packed {
        logic [15:0] result_size;
        logic        was_hit;
    } t_out;

    // Scan token that walks the row of cells once per command.
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             match;
        logic [IDX_W-1:0] midx;
        logic [15:0]      msize;
        logic [31:0]      mcap;
        logic             stop;
        logic [IDX_W-1:0] vidx;
        logic [31:0]      vstamp;
    } t_tok;

    // Write beat broadcast to all cells at the end of a command.
    typedef struct packed {
        logic             we;
        logic             stamp_only;
        logic [IDX_W-1:0] widx;
        logic [31:0]      wkey;
        logic [15:0]      wsize;
        logic [31:0]      wcap;
        logic [31:0]      wstamp;
        logic             clr;
        logic [IDX_W-1:0] cidx;
        logic             forget;
        logic [31:0]      fkey;
    } t_wr;

endpackage

@@ sv/lru_size_latch_table.sv @@
// Top level of the LRU size latch table: command register, row of cells,
// rebuild unit and the write-back control. Depends on lru_pkg, lru_cell, lru_rebuild.
//
// Usage: drive i_cmd and raise start while busy is low; the command beat is
// taken at that edge and busy stays high until the command is finished.
// Commands: latch a size for a key, look up a size, forget a key.
// A lookup gives exactly one result beat: o_done is high for one cycle with
// o_res valid. Latch and forget give no result beat.
// Every command runs from the accepting edge through the scan of the row, the
// capture of its result (S_SCAN) and the write-back (S_APPLY), where a lookup
// raises its result strobe. Busy falls in the same cycle as the strobe, so a
// new command is taken only once the last one is finished. The scan token
// walks the row of cells one cell per clock.
// The size rebuild runs alongside the scan, one scale step per cycle.
// The result receiver cannot stall: a beat is taken in the cycle it shows.
// Reset (synchronous, active low) empties every slot, zeroes the use tick
// and returns the block to idle.
module lru_size_latch_table (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  lru_pkg::t_in  i_cmd,
    output logic          o_done,
    output lru_pkg::t_out o_res
);
    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_APPLY} t_state;

    t_state        r_state;
    lru_pkg::t_in  r_in;
    logic          r_inject;
    lru_pkg::t_tok r_res;
    logic [31:0]   r_tick;
    lru_pkg::t_tok tok [lru_pkg::SLOTS+1];
    lru_pkg::t_wr  wr;
    logic          rb_done;
    logic [15:0]   rb_size;
    logic          key_nz;
    logic          cap_hit;
    logic [31:0]   tick1;

    assign busy = (r_state != S_IDLE);

    always_comb begin
        tok[0]       = '0;
        tok[0].valid = r_inject;
        tok[0].first = 1'b1;
    end

    genvar g;
    generate
        for (g = 0; g < lru_pkg::SLOTS; g++) begin : g_cell
            lru_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_idx   (lru_pkg::IDX_W'(g)),
                .i_key   (r_in.key),
                .i_tok   (tok[g]),
                .i_wr    (wr),
                .o_tok   (tok[g+1])
            );
        end
    endgenerate

    lru_rebuild u_rebuild (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_inject),
        .i_native (r_in.size_value),
        .i_cap    (r_in.block_capacity),
        .o_done   (rb_done),
        .o_size   (rb_size)
    );

    assign key_nz  = (r_in.key != 32'd0);
    assign cap_hit = r_res.match && (r_in.block_capacity != 32'd0) &&
                     (r_in.block_capacity == r_res.mcap);
    assign tick1   = r_tick + 32'd1;

    always_comb begin
        wr        = '0;
        wr.widx   = r_res.match ? r_res.midx : r_res.vidx;
        wr.wkey   = r_in.key;
        wr.wsize  = r_in.size_value;
        wr.wcap   = r_in.block_capacity;
        wr.wstamp = tick1;
        wr.cidx   = r_res.midx;
        wr.fkey   = r_in.key;
        if (r_state == S_APPLY && rb_done && key_nz) begin
            case (r_in.command)
                lru_pkg::CMD_LATCH: begin
                    wr.we = 1'b1;
                end
                lru_pkg::CMD_LOOKUP: begin
                    wr.we = 1'b1;
                    if (cap_hit) begin
                        wr.stamp_only = 1'b1;
                        wr.widx       = r_res.midx;
                    end else begin
                        wr.widx  = r_res.vidx;
                        wr.wsize = rb_size;
                        wr.clr   = r_res.match;
                    end
                end
                lru_pkg::CMD_FORGET: begin
                    wr.forget = 1'b1;
                end
                default: begin
                    wr.we = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_inject <= 1'b0;
            r_tick   <= '0;
            r_res    <= '0;
            o_done   <= 1'b0;
        end else begin
            r_inject <= 1'b0;
            o_done   <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_in     <= i_cmd;
                        r_inject <= 1'b1;
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (tok[lru_pkg::SLOTS].valid) begin
                        r_res   <= tok[lru_pkg::SLOTS];
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    if (rb_done) begin
                        r_state <= S_IDLE;
                        if (key_nz && (r_in.command == lru_pkg::CMD_LATCH ||
                                       r_in.command == lru_pkg::CMD_LOOKUP)) begin
                            r_tick <= tick1;
                        end
                        if (r_in.command == lru_pkg::CMD_LOOKUP) begin
                            o_done <= 1'b1;
                            if (!key_nz) begin
                                o_res.result_size <= r_in.size_value;
                                o_res.was_hit     <= 1'b0;
                            end else if (cap_hit) begin
                                o_res.result_size <= r_res.msize;
                                o_res.was_hit     <= 1'b1;
                            end else begin
                                o_res.result_size <= rb_size;
                                o_res.was_hit     <= 1'b0;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule

@@ sv/lru_cell.sv @@
// One table entry with its share of the match and victim scan.
// Depends on lru_pkg.
module lru_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [lru_pkg::IDX_W-1:0] i_idx,
    input  logic [31:0]               i_key,
    input  lru_pkg::t_tok             i_tok,
    input  lru_pkg::t_wr              i_wr,
    output lru_pkg::t_tok             o_tok
);
    logic [31:0]   r_key;
    logic [15:0]   r_size;
    logic [31:0]   r_cap;
    logic [31:0]   r_stamp;
    lru_pkg::t_tok r_tok;
    lru_pkg::t_tok n_tok;
    logic          hit;

    assign hit = (i_key != 32'd0) && (r_key == i_key);

    always_comb begin
        n_tok = i_tok;
        if (!i_tok.match && hit) begin
            n_tok.match = 1'b1;
            n_tok.midx  = i_idx;
            n_tok.msize = r_size;
            n_tok.mcap  = r_cap;
        end
        // A matching slot counts as empty; a lookup miss clears or refills it.
        if (!i_tok.stop) begin
            if (r_key == 32'd0 || hit) begin
                n_tok.stop = 1'b1;
                n_tok.vidx = i_idx;
            end else if (i_tok.first || r_stamp < i_tok.vstamp) begin
                n_tok.vidx   = i_idx;
                n_tok.vstamp = r_stamp;
            end
        end
        n_tok.first = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key   <= '0;
            r_size  <= '0;
            r_cap   <= '0;
            r_stamp <= '0;
            r_tok   <= '0;
        end else begin
            r_tok <= i_tok.valid ? n_tok : '0;
            if (i_wr.we && i_wr.widx == i_idx) begin
                r_stamp <= i_wr.wstamp;
                if (!i_wr.stamp_only) begin
                    r_key  <= i_wr.wkey;
                    r_size <= i_wr.wsize;
                    r_cap  <= i_wr.wcap;
                end
            end else if ((i_wr.clr && i_wr.cidx == i_idx) ||
                         (i_wr.forget && r_key == i_wr.fkey)) begin
                r_key   <= '0;
                r_size  <= '0;
                r_cap   <= '0;
                r_stamp <= '0;
            end
        end
    end

    assign o_tok = r_tok;
endmodule

@@ sv/lru_rebuild.sv @@
// Rebuilds a size from native size and capacity, one scale step per cycle.
// Depends on lru_pkg.
module lru_rebuild (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_native,
    input  logic [31:0] i_cap,
    output logic        o_done,
    output logic [15:0] o_size
);
    logic [2:0]  r_shift;
    logic        r_busy;
    logic        r_done;
    logic [15:0] r_size;
    logic [19:0] side;
    logic [39:0] square;
    logic        fits;

    assign side   = {4'd0, i_native} << r_shift;
    assign square = side * side;
    assign fits   = square <= {8'd0, i_cap};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_shift <= '0;
        end else if (i_start) begin
            r_shift <= 3'(lru_pkg::TOP_SHIFT);
            r_done  <= 1'b0;
            r_busy  <= 1'b1;
        end else if (r_busy) begin
            if (i_native == 16'd0 || i_cap == 32'd0) begin
                r_size <= i_native;
                r_done <= 1'b1;
                r_busy <= 1'b0;
            end else if (fits || r_shift == 3'd0) begin
                r_size <= fits ? side[15:0] : i_native;
                r_done <= 1'b1;
                r_busy <= 1'b0;
            end else begin
                r_shift <= r_shift - 3'd1;
            end
        end
    end

    assign o_done = r_done;
    assign o_size = r_size;
endmodule
